@@ design/mnq_pkg.sv @@
// Shared types and constants for the MIDI note event ring queue.
// No dependencies; the interfaces and the top module refer to this package by scoped names.

package mnq_pkg;

   localparam int DEFAULT_QUEUE_DEPTH = 256;
   localparam int COUNT_OUT_W         = 9;
   localparam int DATA_W              = 7;

   // Upper nibble of the status byte selects the message type.
   localparam logic [3:0] MSG_NOTE_OFF    = 4'h8;
   localparam logic [3:0] MSG_NOTE_ON     = 4'h9;
   localparam logic [3:0] MSG_CTRL_CHANGE = 4'hB;

   typedef enum logic [1:0] {
      EVT_RELEASE = 2'd0,
      EVT_PRESS   = 2'd1,
      EVT_UNKNOWN = 2'd2
   } evt_kind_type;

   // One stored event: type in the top bits, then velocity, then note.
   typedef struct packed {
      evt_kind_type        kind;
      logic [DATA_W-1:0]   velocity;
      logic [DATA_W-1:0]   note;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

@@ design/mnq_req_if.sv @@
// Request channel of the MIDI note event ring queue: valid/ready plus one input item.
// Depends on mnq_pkg for field widths.

interface mnq_req_if;
   logic                          valid;
   logic                          ready;
   logic                          kind;
   logic [7:0]                    status_byte;
   logic [mnq_pkg::DATA_W-1:0]    first_data;
   logic [mnq_pkg::DATA_W-1:0]    second_data;

   modport source (output valid, kind, status_byte, first_data, second_data, input ready);
   modport sink   (input valid, kind, status_byte, first_data, second_data, output ready);
endinterface

@@ design/mnq_rsp_if.sv @@
// Response channel of the MIDI note event ring queue: valid/ready plus one result item.
// Depends on mnq_pkg for field widths.

interface mnq_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             event_stored;
   logic                             overwrote_oldest;
   logic                             pop_valid;
   logic [mnq_pkg::DATA_W-1:0]       note_out;
   logic [mnq_pkg::DATA_W-1:0]       velocity_out;
   logic [1:0]                       event_type;
   logic [mnq_pkg::COUNT_OUT_W-1:0]  queue_count;

   modport source (output valid, event_stored, overwrote_oldest, pop_valid, note_out,
                   velocity_out, event_type, queue_count, input ready);
   modport sink   (input valid, event_stored, overwrote_oldest, pop_valid, note_out,
                   velocity_out, event_type, queue_count, output ready);
endinterface

@@ design/mnq_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; contents are not reset.

module mnq_ram #(
   parameter int  WIDTH = 16,
   parameter int  DEPTH = 256,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/midi_note_event_ring_queue_top.sv @@
// MIDI note event ring queue: classifies note/controller messages into a circular event store.
// Results and RAM reads are registered in the cycle after acceptance.
// One item per cycle unless the sink stalls; the event RAM does one write or read per item.
// Synchronous reset clears the pointers, the entry count and the result valid flag.
// The event RAM is not cleared: only counted entries are ever read, so no clearing pass runs.
// Depends on mnq_pkg, mnq_req_if, mnq_rsp_if and mnq_ram.

module midi_note_event_ring_queue_top #(
   parameter int QUEUE_DEPTH = mnq_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   mnq_req_if.sink    req_chan,
   mnq_rsp_if.source  rsp_chan
);

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR   = PW'(QUEUE_DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);

   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              stored_ff, stored_in;
   logic                              overwrote_ff, overwrote_in;
   logic                              popped_ff, popped_in;
   logic [mnq_pkg::COUNT_OUT_W-1:0]   count_out_ff, count_out_in;

   logic                   accept;
   logic                   keep;
   mnq_pkg::evt_kind_type  evt_kind;
   logic                   is_store;
   logic                   is_pop;
   logic                   full;
   mnq_pkg::entry_type     wr_entry;
   mnq_pkg::entry_type     rd_entry;
   logic [mnq_pkg::ENTRY_W-1:0] ram_rd_data;

   function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
      next_ptr = (p == LAST_PTR) ? '0 : p + 1'b1;
   endfunction

   // The result register frees up whenever the sink takes the held item.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      keep     = 1'b1;
      evt_kind = mnq_pkg::EVT_UNKNOWN;
      unique case (req_chan.status_byte[7:4])
         mnq_pkg::MSG_NOTE_ON: begin
            evt_kind = (req_chan.second_data == '0) ? mnq_pkg::EVT_RELEASE
                                                    : mnq_pkg::EVT_PRESS;
         end
         mnq_pkg::MSG_NOTE_OFF: begin
            evt_kind = mnq_pkg::EVT_RELEASE;
         end
         mnq_pkg::MSG_CTRL_CHANGE: begin
            evt_kind = mnq_pkg::EVT_UNKNOWN;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign full     = (count_ff == FULL_COUNT);
   assign is_store = accept && !req_chan.kind && keep;
   assign is_pop   = accept && req_chan.kind && (count_ff != '0);

   assign wr_entry.kind     = evt_kind;
   assign wr_entry.velocity = req_chan.second_data;
   assign wr_entry.note     = req_chan.first_data;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (is_store) begin
         wr_ptr_in = next_ptr(wr_ptr_ff);
         // A full queue drops its oldest entry, so the count holds.
         if (full) begin
            rd_ptr_in = next_ptr(rd_ptr_ff);
         end else begin
            count_in = count_ff + 1'b1;
         end
      end else if (is_pop) begin
         rd_ptr_in = next_ptr(rd_ptr_ff);
         count_in  = count_ff - 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign stored_in    = is_store;
   assign overwrote_in = is_store && full;
   assign popped_in    = is_pop;
   assign count_out_in = mnq_pkg::COUNT_OUT_W'(count_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stored_ff    <= stored_in;
         overwrote_ff <= overwrote_in;
         popped_ff    <= popped_in;
         count_out_ff <= count_out_in;
      end
   end

   // The RAM read data holds until the next pop, which only follows acceptance of a new item,
   // so it stays aligned with the result register while the sink stalls.
   mnq_ram #(
      .WIDTH (mnq_pkg::ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_event_ram (
      .clock   (clock),
      .wr_en   (is_store),
      .wr_addr (wr_ptr_ff),
      .wr_data (wr_entry),
      .rd_en   (is_pop),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rd_data)
   );

   assign rd_entry = mnq_pkg::entry_type'(ram_rd_data);

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.event_stored     = stored_ff;
   assign rsp_chan.overwrote_oldest = overwrote_ff;
   assign rsp_chan.pop_valid        = popped_ff;
   assign rsp_chan.note_out         = popped_ff ? rd_entry.note : '0;
   assign rsp_chan.velocity_out     = popped_ff ? rd_entry.velocity : '0;
   assign rsp_chan.event_type       = popped_ff ? rd_entry.kind : mnq_pkg::EVT_RELEASE;
   assign rsp_chan.queue_count      = count_out_ff;

`ifndef ASSERT_OFF
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count exceeds queue depth");

   a_ptr_meet : assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == FULL_COUNT) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("pointers disagree with an empty or full queue");

   a_empty_pop : assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.kind && count_ff == '0) |=>
         (count_ff == $past(count_ff) && rd_ptr_ff == $past(rd_ptr_ff)))
      else $error("pop on an empty queue changed the queue state");

   a_store_xor_pop : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(stored_ff && popped_ff))
      else $error("one item both stored and popped");

   a_overwrite_full : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && overwrote_ff) |->
         (stored_ff && count_out_ff == mnq_pkg::COUNT_OUT_W'(QUEUE_DEPTH)))
      else $error("overwrite reported without a full queue");
`endif

endmodule

@@ verif/mnq_event_checker.sv @@
`timescale 1ns / 100ps
// Result checker for the MIDI note event ring queue: mirrors the event store and checks each item.
// Depends on mnq_pkg, mnq_req_if and mnq_rsp_if; it only watches the two channels.

module mnq_event_checker #(
   parameter int QUEUE_DEPTH = mnq_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic  clock,
   input  logic  reset,
   mnq_req_if    req_mon,
   mnq_rsp_if    rsp_mon,
   output int    fail_count,
   output int    pending_results
);

   typedef struct packed {
      logic                              stored;
      logic                              overwrote;
      logic                              popped;
      logic [mnq_pkg::DATA_W-1:0]        note;
      logic [mnq_pkg::DATA_W-1:0]        velocity;
      logic [1:0]                        evt;
      logic [mnq_pkg::COUNT_OUT_W-1:0]   count;
   } queue_outcome_type;

   mnq_pkg::entry_type  held_events[$];
   queue_outcome_type   pending_outcomes[$];

   // Applies one item to the mirrored queue and returns the result it should produce.
   function automatic queue_outcome_type queue_outcome(
      input logic                       kind,
      input logic [7:0]                 status,
      input logic [mnq_pkg::DATA_W-1:0] first,
      input logic [mnq_pkg::DATA_W-1:0] second);
      queue_outcome_type   res;
      mnq_pkg::entry_type  ev;
      logic                keep;
      res         = '0;
      keep        = 1'b1;
      ev.note     = first;
      ev.velocity = second;
      ev.kind     = mnq_pkg::EVT_UNKNOWN;
      if (!kind) begin
         unique case (status[7:4])
            mnq_pkg::MSG_NOTE_ON: begin
               if (second == '0) ev.kind = mnq_pkg::EVT_RELEASE;
               else ev.kind = mnq_pkg::EVT_PRESS;
            end
            mnq_pkg::MSG_NOTE_OFF:    ev.kind = mnq_pkg::EVT_RELEASE;
            mnq_pkg::MSG_CTRL_CHANGE: ev.kind = mnq_pkg::EVT_UNKNOWN;
            default:                  keep = 1'b0;
         endcase
         if (keep) begin
            // A full queue drops its oldest entry to make room.
            if (held_events.size() >= QUEUE_DEPTH) begin
               void'(held_events.pop_front());
               res.overwrote = 1'b1;
            end
            held_events.push_back(ev);
            res.stored = 1'b1;
         end
      end else if (held_events.size() != 0) begin
         ev           = held_events.pop_front();
         res.popped   = 1'b1;
         res.note     = ev.note;
         res.velocity = ev.velocity;
         res.evt      = ev.kind;
      end
      res.count = mnq_pkg::COUNT_OUT_W'(held_events.size());
      return res;
   endfunction

   function automatic string outcome_text(input queue_outcome_type o);
      return $sformatf("stored=%b ovw=%b pop=%b note=%0d vel=%0d type=%0d count=%0d",
                       o.stored, o.overwrote, o.popped, o.note, o.velocity, o.evt, o.count);
   endfunction

   queue_outcome_type  expected;
   queue_outcome_type  actual;

   always @(posedge clock) begin
      if (reset) begin
         held_events.delete();
         pending_outcomes.delete();
         fail_count = 0;
      end else begin
         // Results are checked before the new item is queued, since the block registers each result.
         if (rsp_mon.valid && rsp_mon.ready) begin
            actual = {rsp_mon.event_stored, rsp_mon.overwrote_oldest, rsp_mon.pop_valid,
                      rsp_mon.note_out, rsp_mon.velocity_out, rsp_mon.event_type,
                      rsp_mon.queue_count};
            if (pending_outcomes.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected result %s", $realtime, outcome_text(actual));
            end else begin
               expected = pending_outcomes.pop_front();
               if (actual !== expected) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("%0t: result mismatch", $realtime);
                     $display("   expected %s", outcome_text(expected));
                     $display("   actual   %s", outcome_text(actual));
                  end
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            pending_outcomes.push_back(queue_outcome(req_mon.kind, req_mon.status_byte,
                                                     req_mon.first_data, req_mon.second_data));
      end
      pending_results = pending_outcomes.size();
   end

endmodule

@@ verif/tb_midi_note_event_ring_queue_top.sv @@
`timescale 1ns / 100ps
// Testbench top for the MIDI note event ring queue: clock, reset, stimulus and the verdict.
// Depends on mnq_pkg, both channel interfaces, the block itself and mnq_event_checker.

module tb_midi_note_event_ring_queue_top;

   localparam int DEPTH       = mnq_pkg::DEFAULT_QUEUE_DEPTH;
   localparam int CYCLE_LIMIT = 200000;

   logic  clock = 1'b0;
   logic  reset = 1'b1;
   int    send_idle_pct;
   int    recv_stall_pct;
   int    cycle_count;
   int    fail_count;
   int    pending_results;

   always #2 clock = ~clock;

   mnq_req_if req_chan ();
   mnq_rsp_if rsp_chan ();

   midi_note_event_ring_queue_top #(.QUEUE_DEPTH(DEPTH)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   mnq_event_checker #(.QUEUE_DEPTH(DEPTH)) u_event_check (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_chan),
      .rsp_mon         (rsp_chan),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL midi_note_event_ring_queue_top");
         $finish;
      end
   end

   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Presents one item from a falling edge and holds it until the block takes it.
   task automatic send_item(input logic kind, input logic [7:0] status,
                            input logic [mnq_pkg::DATA_W-1:0] first,
                            input logic [mnq_pkg::DATA_W-1:0] second);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.kind        <= kind;
      req_chan.status_byte <= status;
      req_chan.first_data  <= first;
      req_chan.second_data <= second;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic send_pop();
      send_item(1'b1, 8'($urandom), 7'($urandom), 7'($urandom));
   endtask

   task automatic send_random(input int pop_pct);
      logic [3:0]  msg;
      logic [6:0]  vel;
      if ($urandom_range(99) < pop_pct) begin
         send_pop();
      end else if ($urandom_range(99) < 85) begin
         case ($urandom_range(2))
            0:       msg = mnq_pkg::MSG_NOTE_OFF;
            1:       msg = mnq_pkg::MSG_NOTE_ON;
            default: msg = mnq_pkg::MSG_CTRL_CHANGE;
         endcase
         // Zero velocity is favored so that Note On releases show up often.
         vel = ($urandom_range(3) == 0) ? 7'd0 : 7'($urandom_range(127));
         send_item(1'b0, {msg, 4'($urandom_range(15))}, 7'($urandom), vel);
      end else begin
         send_item(1'b0, 8'($urandom_range(255)), 7'($urandom), 7'($urandom));
      end
   endtask

   // Drops valid and holds off until every outstanding result has come back.
   task automatic wait_drain();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
   endtask

   task automatic run_phase(input int idle, input int stall, input int pop_pct,
                            input int count);
      send_idle_pct  = idle;
      recv_stall_pct = stall;
      repeat (count) send_random(pop_pct);
   endtask

   initial begin
      req_chan.valid       = 1'b0;
      req_chan.kind        = 1'b0;
      req_chan.status_byte = '0;
      req_chan.first_data  = '0;
      req_chan.second_data = '0;
      send_idle_pct        = 0;
      recv_stall_pct       = 0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Directed items: pop on empty, every stored type at the data extremes, ignored types.
      send_pop();
      send_item(1'b0, 8'h9F, 7'd127, 7'd127);
      send_item(1'b0, 8'h90, 7'd0, 7'd0);
      send_item(1'b0, 8'h80, 7'd127, 7'd127);
      send_item(1'b0, 8'h8F, 7'd0, 7'd0);
      send_item(1'b0, 8'hB0, 7'd127, 7'd0);
      send_item(1'b0, 8'hBF, 7'd0, 7'd127);
      send_item(1'b0, 8'hA3, 7'd5, 7'd9);
      send_item(1'b0, 8'hC0, 7'd127, 7'd127);
      send_item(1'b0, 8'hD7, 7'd1, 7'd1);
      send_item(1'b0, 8'hE0, 7'd64, 7'd64);
      send_item(1'b0, 8'hF0, 7'd3, 7'd0);
      send_item(1'b0, 8'hF8, 7'd0, 7'd0);
      send_item(1'b0, 8'hFF, 7'd127, 7'd127);
      send_item(1'b0, 8'h00, 7'd10, 7'd20);
      send_item(1'b0, 8'h7F, 7'd127, 7'd127);
      repeat (7) send_pop();

      // Store-heavy phase first, to push the queue toward full so that it drops its oldest entries.
      run_phase(0, 0, 4, 300);
      run_phase(86, 0, 60, 180);
      wait_drain();
      run_phase(0, 86, 20, 180);
      run_phase(15, 15, 75, 190);

      wait_drain();
      repeat (4) @(posedge clock);
      if (fail_count == 0 && pending_results == 0) begin
         $display("PASS midi_note_event_ring_queue_top");
      end else begin
         $display("FAIL midi_note_event_ring_queue_top");
      end
      $finish;
   end

endmodule

@@ sim.f @@
design/mnq_pkg.sv
design/mnq_req_if.sv
design/mnq_rsp_if.sv
design/mnq_ram.sv
design/midi_note_event_ring_queue_top.sv
verif/mnq_event_checker.sv
verif/tb_midi_note_event_ring_queue_top.sv
